/* rtl/imdiv_pkg.sv */
// Shared types and helpers for the invariant-divisor magic divider.
// Used by imdiv_div_stage and invariant_divisor_magic_divider.
package imdiv_pkg;

	localparam int unsigned W      = 32;
	localparam int unsigned LW     = 5;
	localparam logic [W-1:0] HALF  = 32'h8000_0000;
	localparam logic [W-1:0] ONES  = 32'hffff_ffff;

	// side information carried alongside the division
	typedef struct packed {
		logic [W-1:0]  divisor;
		logic [W-1:0]  dividend;
		logic [LW-1:0] lg;
		logic          zero;
		logic          pow2;
		logic          one;
	} side_t;

	function automatic logic [LW-1:0] floor_log2(input logic [W-1:0] v);
		logic [LW-1:0] r;
		r = '0;
		for (int i = 0; i < W; i++) begin
			if (v[i]) begin
				r = LW'(i);
			end
		end
		return r;
	endfunction

endpackage

/* rtl/imdiv_div_stage.sv */
// One restoring-division step of the 2^63 / normalised-divisor pipeline.
// Depends on imdiv_pkg.
module imdiv_div_stage (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 valid_i,
	input  logic [31:0]          rem_i,
	input  logic [31:0]          quo_i,
	input  logic [31:0]          dn_i,
	input  imdiv_pkg::side_t     side_i,
	output logic                 valid_s,
	output logic [31:0]          rem_s,
	output logic [31:0]          quo_s,
	output logic [31:0]          dn_s,
	output imdiv_pkg::side_t     side_s
);
	import imdiv_pkg::*;

	logic [W:0]   shifted;
	logic [W:0]   diff;
	logic         ge;

	// dividend bits below the top word are all zero
	assign shifted = {rem_i, 1'b0};
	assign diff    = shifted - {1'b0, dn_i};
	assign ge      = (shifted >= {1'b0, dn_i});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= 1'b0;
		end else if (en) begin
			valid_s <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s  <= ge ? diff[W-1:0] : shifted[W-1:0];
			quo_s  <= {quo_i[W-2:0], ge};
			dn_s   <= dn_i;
			side_s <= side_i;
		end
	end

endmodule

/* rtl/invariant_divisor_magic_divider.sv */
// Top level of the invariant-divisor magic divider.
// Depends on imdiv_pkg and imdiv_div_stage.
//
// Takes one divisor/dividend request per cycle while the output is not stalled
// and returns the magic constants (mul, add, shift) for the divisor, together
// with the quotient and remainder obtained by multiply-add-shift. One stage
// finds floor(log2) and normalises the divisor so its top bit is set, 32 stages
// each retire one quotient bit of 2^63 / normalised divisor, then one stage
// picks round-up or round-down constants, one forms dividend*mul, one adds and
// shifts, one forms quotient*divisor and the last subtracts to give the
// remainder. Sustained rate is one request per cycle; a stall at the output
// freezes the whole pipe, so nothing is lost or repeated. A zero divisor sets
// zero_divisor and zeroes every other field.
module invariant_divisor_magic_divider (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] divisor,
	input  logic [31:0] dividend,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] magic_mul,
	output logic [31:0] magic_add,
	output logic [4:0]  magic_shift,
	output logic [31:0] quotient,
	output logic [31:0] remainder,
	output logic        zero_divisor
);
	import imdiv_pkg::*;

	localparam int unsigned NDIV = W;

	logic en;
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	// ---- stage 1: log2 and normalisation
	logic          valid_s1;
	logic [W-1:0]  dn_s1;
	side_t         side_s1;
	logic [LW-1:0] lg_c;

	assign lg_c = floor_log2(divisor);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dn_s1            <= divisor << (LW'(W-1) - lg_c);
			side_s1.divisor  <= divisor;
			side_s1.dividend <= dividend;
			side_s1.lg       <= lg_c;
			side_s1.zero     <= (divisor == '0);
			side_s1.pow2     <= (divisor != '0) && ((divisor & (divisor - 1'b1)) == '0);
			side_s1.one      <= (divisor == W'(1));
		end
	end

	// ---- stage 2: restoring division chain, one quotient bit per step
	logic         dv_valid [NDIV+1];
	logic [W-1:0] dv_rem   [NDIV+1];
	logic [W-1:0] dv_quo   [NDIV+1];
	logic [W-1:0] dv_dn    [NDIV+1];
	side_t        dv_side  [NDIV+1];

	// top word of 2^63 is HALF; below the normalised divisor unless a power of two
	assign dv_valid[0] = valid_s1;
	assign dv_rem[0]   = HALF;
	assign dv_quo[0]   = '0;
	assign dv_dn[0]    = dn_s1;
	assign dv_side[0]  = side_s1;

	for (genvar g = 0; g < NDIV; g++) begin : g_div
		imdiv_div_stage u_stage (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.valid_i (dv_valid[g]),
			.rem_i   (dv_rem[g]),
			.quo_i   (dv_quo[g]),
			.dn_i    (dv_dn[g]),
			.side_i  (dv_side[g]),
			.valid_s (dv_valid[g+1]),
			.rem_s   (dv_rem[g+1]),
			.quo_s   (dv_quo[g+1]),
			.dn_s    (dv_dn[g+1]),
			.side_s  (dv_side[g+1])
		);
	end

	// ---- stage 3: choose constants
	logic          valid_s3;
	logic [W-1:0]  mul_s3;
	logic [W-1:0]  add_s3;
	logic [LW-1:0] sh_s3;
	side_t         side_s3;
	logic [W-1:0]  gap_c;
	side_t         sd;

	assign sd = dv_side[NDIV];
	// divisor - remainder, scaled by the normalising shift; below 2^31 means round up
	assign gap_c = dv_dn[NDIV] - dv_rem[NDIV];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= dv_valid[NDIV];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s3 <= sd;
			priority if (sd.zero) begin
				mul_s3 <= '0;
				add_s3 <= '0;
				sh_s3  <= '0;
			end else if (sd.one) begin
				mul_s3 <= ONES;
				add_s3 <= ONES;
				sh_s3  <= '0;
			end else if (sd.pow2) begin
				mul_s3 <= HALF;
				add_s3 <= '0;
				sh_s3  <= sd.lg - 1'b1;
			end else if (!gap_c[W-1]) begin
				mul_s3 <= dv_quo[NDIV] + 1'b1;
				add_s3 <= '0;
				sh_s3  <= sd.lg;
			end else begin
				mul_s3 <= dv_quo[NDIV];
				add_s3 <= dv_quo[NDIV];
				sh_s3  <= sd.lg;
			end
		end
	end

	// ---- stage 4: dividend * mul
	logic          valid_s4;
	logic [2*W-1:0] prod_s4;
	logic [W-1:0]  mul_s4;
	logic [W-1:0]  add_s4;
	logic [LW-1:0] sh_s4;
	side_t         side_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s4 <= {{W{1'b0}}, side_s3.dividend} * {{W{1'b0}}, mul_s3};
			mul_s4  <= mul_s3;
			add_s4  <= add_s3;
			sh_s4   <= sh_s3;
			side_s4 <= side_s3;
		end
	end

	// ---- stage 5: add, take high word, shift
	logic          valid_s5;
	logic [W-1:0]  quo_s5;
	logic [W-1:0]  mul_s5;
	logic [W-1:0]  add_s5;
	logic [LW-1:0] sh_s5;
	side_t         side_s5;
	logic [2*W-1:0] sum_c;

	assign sum_c = prod_s4 + {{W{1'b0}}, add_s4};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else if (en) begin
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quo_s5  <= side_s4.zero ? '0 : (sum_c[2*W-1:W] >> sh_s4);
			mul_s5  <= mul_s4;
			add_s5  <= add_s4;
			sh_s5   <= sh_s4;
			side_s5 <= side_s4;
		end
	end

	// ---- stage 6: quotient * divisor, low word only
	logic          valid_s6;
	logic [W-1:0]  qd_s6;
	logic [W-1:0]  quo_s6;
	logic [W-1:0]  mul_s6;
	logic [W-1:0]  add_s6;
	logic [LW-1:0] sh_s6;
	side_t         side_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6 <= 1'b0;
		end else if (en) begin
			valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			qd_s6   <= quo_s5 * side_s5.divisor;
			quo_s6  <= quo_s5;
			mul_s6  <= mul_s5;
			add_s6  <= add_s5;
			sh_s6   <= sh_s5;
			side_s6 <= side_s5;
		end
	end

	// ---- stage 7: remainder and output register
	logic          valid_s7;
	logic [W-1:0]  rem_s7;
	logic [W-1:0]  quo_s7;
	logic [W-1:0]  mul_s7;
	logic [W-1:0]  add_s7;
	logic [LW-1:0] sh_s7;
	logic [W-1:0]  div_s7;
	logic          zero_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s7 <= 1'b0;
		end else if (en) begin
			valid_s7 <= valid_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s7  <= side_s6.zero ? '0 : (side_s6.dividend - qd_s6);
			quo_s7  <= quo_s6;
			mul_s7  <= mul_s6;
			add_s7  <= add_s6;
			sh_s7   <= sh_s6;
			div_s7  <= side_s6.divisor;
			zero_s7 <= side_s6.zero;
		end
	end

	assign out_valid    = valid_s7;
	assign magic_mul    = mul_s7;
	assign magic_add    = add_s7;
	assign magic_shift  = sh_s7;
	assign quotient     = quo_s7;
	assign remainder    = rem_s7;
	assign zero_divisor = zero_s7;

	// remainder always below a nonzero divisor
	a_rem_lt_div: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s7 && !zero_s7 |-> (rem_s7 < div_s7))
		else $error("remainder not below divisor");

	// magic multiplier for a nonzero divisor that is not a power of two is at least 2^31
	a_mul_top: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && !side_s3.zero && !side_s3.pow2 |-> mul_s3[W-1])
		else $error("magic multiplier below 2^31");

	// zero divisor clears the quotient, remainder and multiplier fields
	a_zero_out: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s7 && zero_s7 |-> (quo_s7 == '0 && rem_s7 == '0 && mul_s7 == '0))
		else $error("zero divisor result not cleared");

endmodule
